// ===== rtl/core/cpfa_pkg.sv =====
`timescale 1ns / 1ps
package cpfa_pkg;

  // Frame count is a power of two so that clock order slots wrap by truncation.
  localparam int FRAME_BITS = 6;
  localparam int NUM_FRAMES = 1 << FRAME_BITS;
  localparam int CNT_BITS   = FRAME_BITS + 1;
  localparam int BLOCK_BITS = 16;

  localparam logic [CNT_BITS-1:0] FRAMES_RESET = CNT_BITS'(NUM_FRAMES);
  localparam logic [CNT_BITS-1:0] FRAMES_MIN   = CNT_BITS'(2);

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_ACCESS  = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [FRAME_BITS-1:0] frame;
    logic                  write_access;
    logic                  backing_kind;
    logic [BLOCK_BITS-1:0] backing_block;
  } in_item_t;

  typedef struct packed {
    logic                  status;
    logic [FRAME_BITS-1:0] granted_frame;
    logic                  victim_valid;
    logic                  victim_writeback;
    logic                  victim_kind;
    logic [BLOCK_BITS-1:0] victim_block;
  } out_item_t;

  typedef struct packed {
    logic                  used;
    logic                  referenced;
    logic                  dirty;
    logic                  kind;
    logic [BLOCK_BITS-1:0] block;
  } frame_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EV_HEAD,
    ST_EV_FRAME,
    ST_EV_CHECK,
    ST_GRANT,
    ST_FRAME_RD,
    ST_FRAME_CHK,
    ST_COMPACT,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/core/cpfa_ram.sv =====
`timescale 1ns / 1ps
module cpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/clock_page_frame_allocator.sv =====
`timescale 1ns / 1ps
// Access updates the entry of a live frame; release also compacts the clock order;
// allocate scans for a free frame and, when none is free, walks the clock order from
// its head, giving second chances until it finds an unreferenced entry, the victim.
// One transaction at a time: in_stall is high until the result is loaded into the
// output register, so a new item is accepted only once the previous result is loaded.
// Reset (synchronous, rst_n low) returns frames_r to 64.
module clock_page_frame_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cpfa_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cpfa_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [cpfa_pkg::CNT_BITS-1:0]       cfg_wdata
);

  import cpfa_pkg::*;

  state_t                state_r, state_nxt;
  in_item_t              item_r, item_nxt;
  out_item_t             res_r, res_nxt;
  out_item_t             out_data_r, out_data_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [FRAME_BITS-1:0] g_r, g_nxt;
  logic [FRAME_BITS-1:0] head_r, head_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [CNT_BITS-1:0]   scan_i_r, scan_i_nxt;
  logic                  scan_pend_r, scan_pend_nxt;
  logic [FRAME_BITS-1:0] scan_addr_r, scan_addr_nxt;
  logic [CNT_BITS-1:0]   cmp_k_r, cmp_k_nxt;
  logic [CNT_BITS-1:0]   cmp_w_r, cmp_w_nxt;
  logic                  cmp_pend_r, cmp_pend_nxt;
  logic [CNT_BITS-1:0]   frames_r;
  logic [NUM_FRAMES-1:0] fvalid_r;
  logic                  rd_fvalid_r;

  logic                  f_we, f_re;
  logic [FRAME_BITS-1:0] f_waddr, f_raddr;
  frame_entry_t          f_wdata, f_rdata;
  logic                  o_we, o_re;
  logic [FRAME_BITS-1:0] o_waddr, o_raddr, o_wdata, o_rdata;

  logic                  in_accept;
  logic                  out_free;
  logic [CNT_BITS-1:0]   n_act;
  logic                  frame_live;
  logic                  scan_found;
  logic                  scan_more;
  logic                  cmp_more;

  cpfa_ram #(.WIDTH($bits(frame_entry_t)), .DEPTH(NUM_FRAMES)) u_frame_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  cpfa_ram #(.WIDTH(FRAME_BITS), .DEPTH(NUM_FRAMES)) u_order_ram (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .re    (o_re),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign n_act = (frames_r < FRAMES_MIN) ? FRAMES_MIN :
                 (frames_r > FRAMES_RESET) ? FRAMES_RESET : frames_r;

  // Frame 0 is never read; an entry never written reads as not live, as its fvalid_r bit is clear.
  assign frame_live = rd_fvalid_r && f_rdata.used;
  assign scan_found = scan_pend_r && !frame_live;
  assign scan_more  = (scan_i_r < n_act);
  assign cmp_more   = (cmp_k_r < count_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data.cmd == CMD_ALLOC) begin
            state_nxt = ST_SCAN;
          end else if ((in_data.cmd inside {CMD_ACCESS, CMD_RELEASE}) &&
                       (in_data.frame != '0)) begin
            state_nxt = ST_FRAME_RD;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (scan_found) begin
          state_nxt = ST_GRANT;
        end else if (!scan_more) begin
          state_nxt = ST_EV_HEAD;
        end
      end
      ST_EV_HEAD: begin
        state_nxt = (count_r == '0) ? ST_FINISH : ST_EV_FRAME;
      end
      ST_EV_FRAME: state_nxt = ST_EV_CHECK;
      ST_EV_CHECK: begin
        state_nxt = f_rdata.referenced ? ST_EV_HEAD : ST_GRANT;
      end
      ST_GRANT:    state_nxt = ST_FINISH;
      ST_FRAME_RD: state_nxt = ST_FRAME_CHK;
      ST_FRAME_CHK: begin
        state_nxt = (frame_live && item_r.cmd == CMD_RELEASE) ? ST_COMPACT : ST_FINISH;
      end
      ST_COMPACT: begin
        if (!cmp_more && !cmp_pend_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    item_nxt      = item_r;
    res_nxt       = res_r;
    g_nxt         = g_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    scan_i_nxt    = scan_i_r;
    scan_pend_nxt = scan_pend_r;
    scan_addr_nxt = scan_addr_r;
    cmp_k_nxt     = cmp_k_r;
    cmp_w_nxt     = cmp_w_r;
    cmp_pend_nxt  = cmp_pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    f_we          = 1'b0;
    f_waddr       = g_r;
    f_wdata       = f_rdata;
    f_re          = 1'b0;
    f_raddr       = item_r.frame;
    o_we          = 1'b0;
    o_waddr       = head_r + count_r[FRAME_BITS-1:0];
    o_wdata       = g_r;
    o_re          = 1'b0;
    o_raddr       = head_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          item_nxt      = in_data;
          res_nxt       = '0;
          scan_i_nxt    = CNT_BITS'(1);
          scan_pend_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        scan_pend_nxt = 1'b0;
        if (scan_found) begin
          g_nxt = scan_addr_r;
        end else if (scan_more) begin
          f_re          = 1'b1;
          f_raddr       = scan_i_r[FRAME_BITS-1:0];
          scan_addr_nxt = scan_i_r[FRAME_BITS-1:0];
          scan_i_nxt    = scan_i_r + CNT_BITS'(1);
          scan_pend_nxt = 1'b1;
        end
      end
      ST_EV_HEAD: begin
        if (count_r == '0) begin
          res_nxt.status = 1'b1;
        end else begin
          o_re = 1'b1;
        end
      end
      ST_EV_FRAME: begin
        f_re    = 1'b1;
        f_raddr = o_rdata;
        g_nxt   = o_rdata;
      end
      ST_EV_CHECK: begin
        head_nxt = head_r + FRAME_BITS'(1);
        if (f_rdata.referenced) begin
          // Second chance: drop the mark and rotate the head frame to the tail.
          f_we               = 1'b1;
          f_wdata.referenced = 1'b0;
          o_we               = 1'b1;
        end else begin
          res_nxt.victim_valid     = 1'b1;
          res_nxt.victim_writeback = f_rdata.dirty;
          res_nxt.victim_kind      = f_rdata.kind;
          res_nxt.victim_block     = f_rdata.block;
          count_nxt                = count_r - CNT_BITS'(1);
        end
      end
      ST_GRANT: begin
        f_we                  = 1'b1;
        f_wdata.used          = 1'b1;
        f_wdata.referenced    = 1'b1;
        f_wdata.dirty         = item_r.write_access;
        f_wdata.kind          = item_r.backing_kind;
        f_wdata.block         = item_r.backing_block;
        o_we                  = 1'b1;
        count_nxt             = count_r + CNT_BITS'(1);
        res_nxt.granted_frame = g_r;
      end
      ST_FRAME_RD: begin
        f_re = 1'b1;
      end
      ST_FRAME_CHK: begin
        f_waddr = item_r.frame;
        if (frame_live) begin
          case (item_r.cmd)
            CMD_ACCESS: begin
              f_we               = 1'b1;
              f_wdata.referenced = 1'b1;
              f_wdata.dirty      = f_rdata.dirty | item_r.write_access;
            end
            CMD_RELEASE: begin
              f_we               = 1'b1;
              f_wdata.used       = 1'b0;
              f_wdata.referenced = 1'b0;
              f_wdata.dirty      = 1'b0;
              cmp_k_nxt          = '0;
              cmp_w_nxt          = '0;
              cmp_pend_nxt       = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_COMPACT: begin
        // Read slot k while writing back the kept entry at slot w (w < k).
        if (cmp_pend_r && (o_rdata != item_r.frame)) begin
          o_we      = 1'b1;
          o_waddr   = head_r + cmp_w_r[FRAME_BITS-1:0];
          o_wdata   = o_rdata;
          cmp_w_nxt = cmp_w_r + CNT_BITS'(1);
        end
        cmp_pend_nxt = 1'b0;
        if (cmp_more) begin
          o_re         = 1'b1;
          o_raddr      = head_r + cmp_k_r[FRAME_BITS-1:0];
          cmp_k_nxt    = cmp_k_r + CNT_BITS'(1);
          cmp_pend_nxt = 1'b1;
        end else if (!cmp_pend_r) begin
          count_nxt = cmp_w_r;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      count_r     <= '0;
      scan_pend_r <= 1'b0;
      cmp_pend_r  <= 1'b0;
      frames_r    <= FRAMES_RESET;
      fvalid_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      scan_pend_r <= scan_pend_nxt;
      cmp_pend_r  <= cmp_pend_nxt;
      if (cfg_we) begin
        frames_r <= cfg_wdata;
      end
      if (f_we) begin
        fvalid_r[f_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
    g_r         <= g_nxt;
    scan_i_r    <= scan_i_nxt;
    scan_addr_r <= scan_addr_nxt;
    cmp_k_r     <= cmp_k_nxt;
    cmp_w_r     <= cmp_w_nxt;
    if (f_re) begin
      rd_fvalid_r <= fvalid_r[f_raddr];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(NUM_FRAMES - 1))
    else $error("clock order count exceeds the number of grantable frames");

  a_grant_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GRANT) |-> (count_r < CNT_BITS'(NUM_FRAMES - 1)) && (g_r != '0))
    else $error("grant of reserved frame or with a full clock order");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status) |->
      (out_data_r.granted_frame == '0) && !out_data_r.victim_valid)
    else $error("failed allocate reports a frame or a victim");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_free) |=> out_valid_r && (state_r == ST_IDLE))
    else $error("result not loaded when leaving finish");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import cpfa_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN     = 2'd3;
  localparam logic       STATUS_OK       = 1'b0;
  localparam logic       STATUS_NO_FRAME = 1'b1;
  localparam logic       KIND_SWAP       = 1'b0;
  localparam logic       KIND_FILE       = 1'b1;

  localparam int SEGMENTS     = 12;
  localparam int SEG_ITEMS    = 53;
  localparam int SETTLE       = 8;
  localparam int HOLDOFF_LEN  = 400;
  localparam int QUIET_LIMIT  = 5000;

  localparam out_item_t NO_RESULT = '0;

  typedef struct packed {
    logic                do_cfg;
    logic [CNT_BITS-1:0] cfg_val;
    in_item_t            item;
    logic                fixed;
    out_item_t           want;
  } dir_row_t;

  localparam int NDIR = 21;
  localparam dir_row_t DIRECTED [NDIR] = '{
    '{1'b0, 7'd0, '{CMD_ALLOC, 6'd0, 1'b1, KIND_FILE, 16'hFFFF}, 1'b1,
      '{STATUS_OK, 6'd1, 1'b0, 1'b0, 1'b0, 16'h0000}},
    '{1'b0, 7'd0, '{CMD_ALLOC, 6'd0, 1'b0, KIND_SWAP, 16'h0000}, 1'b1,
      '{STATUS_OK, 6'd2, 1'b0, 1'b0, 1'b0, 16'h0000}},
    '{1'b0, 7'd0, '{CMD_ACCESS, 6'd0, 1'b1, KIND_SWAP, 16'h0000}, 1'b1, NO_RESULT},
    '{1'b0, 7'd0, '{CMD_RELEASE, 6'd0, 1'b0, KIND_SWAP, 16'h0000}, 1'b1, NO_RESULT},
    '{1'b0, 7'd0, '{CMD_ACCESS, 6'd63, 1'b1, KIND_FILE, 16'hFFFF}, 1'b1, NO_RESULT},
    '{1'b0, 7'd0, '{CMD_RELEASE, 6'd32, 1'b0, KIND_SWAP, 16'h0000}, 1'b1, NO_RESULT},
    '{1'b0, 7'd0, '{CMD_UNKNOWN, 6'd1, 1'b1, KIND_FILE, 16'hFFFF}, 1'b1, NO_RESULT},
    '{1'b0, 7'd0, '{CMD_ACCESS, 6'd2, 1'b1, KIND_SWAP, 16'h0000}, 1'b1, NO_RESULT},
    '{1'b0, 7'd0, '{CMD_RELEASE, 6'd1, 1'b0, KIND_SWAP, 16'h0000}, 1'b1, NO_RESULT},
    '{1'b0, 7'd0, '{CMD_ALLOC, 6'd0, 1'b0, KIND_FILE, 16'h1234}, 1'b1,
      '{STATUS_OK, 6'd1, 1'b0, 1'b0, 1'b0, 16'h0000}},
    '{1'b0, 7'd0, '{CMD_ALLOC, 6'd63, 1'b1, KIND_SWAP, 16'h8000}, 1'b1,
      '{STATUS_OK, 6'd3, 1'b0, 1'b0, 1'b0, 16'h0000}},
    // shrink below the occupied frames: force second chance and evict above the count
    '{1'b1, 7'd3, '{CMD_ALLOC, 6'd0, 1'b1, KIND_FILE, 16'h00FF}, 1'b0, NO_RESULT},
    '{1'b0, 7'd0, '{CMD_ACCESS, 6'd3, 1'b0, KIND_SWAP, 16'h0000}, 1'b0, NO_RESULT},
    '{1'b0, 7'd0, '{CMD_ALLOC, 6'd0, 1'b0, KIND_SWAP, 16'hAAAA}, 1'b0, NO_RESULT},
    '{1'b0, 7'd0, '{CMD_RELEASE, 6'd3, 1'b0, KIND_SWAP, 16'h0000}, 1'b0, NO_RESULT},
    '{1'b1, 7'd0, '{CMD_ALLOC, 6'd0, 1'b1, KIND_SWAP, 16'h0001}, 1'b0, NO_RESULT},
    '{1'b0, 7'd0, '{CMD_ALLOC, 6'd0, 1'b0, KIND_FILE, 16'hFFFE}, 1'b0, NO_RESULT},
    '{1'b0, 7'd0, '{CMD_ACCESS, 6'd1, 1'b1, KIND_SWAP, 16'h0000}, 1'b0, NO_RESULT},
    '{1'b1, 7'd127, '{CMD_ALLOC, 6'd0, 1'b1, KIND_FILE, 16'h5555}, 1'b0, NO_RESULT},
    '{1'b1, 7'd2, '{CMD_ALLOC, 6'd0, 1'b0, KIND_SWAP, 16'h7FFF}, 1'b0, NO_RESULT},
    '{1'b0, 7'd0, '{CMD_RELEASE, 6'd2, 1'b0, KIND_SWAP, 16'h0000}, 1'b0, NO_RESULT}
  };

  localparam logic [CNT_BITS-1:0] SEG_FRAMES [SEGMENTS] = '{
    7'd64, 7'd4, 7'd2, 7'd127, 7'd9, 7'd0, 7'd48, 7'd3, 7'd1, 7'd16, 7'd64, 7'd6
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CNT_BITS-1:0] cfg_wdata = FRAMES_RESET;

  // expectation override carried alongside each offered transaction
  logic      fixed_valid = 1'b0;
  out_item_t fixed_want = '0;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int active_span = NUM_FRAMES;

  // predicted allocator state
  bit                  pf_used  [NUM_FRAMES];
  bit                  pf_ref   [NUM_FRAMES];
  bit                  pf_dirty [NUM_FRAMES];
  bit                  pf_kind  [NUM_FRAMES];
  logic [BLOCK_BITS-1:0] pf_block [NUM_FRAMES];
  int                  ring     [NUM_FRAMES];
  int                  ring_head;
  int                  ring_count;
  logic [CNT_BITS-1:0] pred_frames;

  out_item_t outcome_q [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_evictions = 0;
  int n_cfg = 0;

  clock_page_frame_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void ring_push(int f);
    if (ring_count < NUM_FRAMES) begin
      ring[(ring_head + ring_count) % NUM_FRAMES] = f;
      ring_count++;
    end
  endfunction

  function automatic void ring_pop();
    if (ring_count > 0) begin
      ring_head = (ring_head + 1) % NUM_FRAMES;
      ring_count--;
    end
  endfunction

  function automatic void ring_drop(int f);
    int w;
    int v;
    w = 0;
    for (int k = 0; k < ring_count; k++) begin
      v = ring[(ring_head + k) % NUM_FRAMES];
      if (v != f) begin
        ring[(ring_head + w) % NUM_FRAMES] = v;
        w++;
      end
    end
    ring_count = w;
  endfunction

  function automatic out_item_t frame_outcome(in_item_t it);
    out_item_t res;
    int n;
    int g;
    int f;
    int guard;
    bit found;
    res = '0;
    g = 0;
    found = 1'b0;
    case (it.cmd)
      CMD_ALLOC: begin
        n = (pred_frames < FRAMES_MIN) ? 2 :
            (pred_frames > FRAMES_RESET) ? NUM_FRAMES : int'(pred_frames);
        for (int i = 0; i < n && !found; i++) begin
          if (!pf_used[i]) begin
            g = i;
            found = 1'b1;
          end
        end
        if (found) begin
          ring_drop(g);
        end else begin
          // second chance: strip referenced marks and rotate until an unmarked head
          guard = 2 * ring_count + 2;
          while (ring_count > 0 && guard > 0 && !found) begin
            f = ring[ring_head];
            guard--;
            if (!pf_ref[f]) begin
              res.victim_valid     = 1'b1;
              res.victim_writeback = pf_dirty[f];
              res.victim_kind      = pf_kind[f];
              res.victim_block     = pf_block[f];
              pf_dirty[f] = 1'b0;
              pf_ref[f]   = 1'b0;
              pf_used[f]  = 1'b0;
              ring_pop();
              g = f;
              found = 1'b1;
            end else begin
              pf_ref[f] = 1'b0;
              ring_pop();
              ring_push(f);
            end
          end
        end
        if (!found) begin
          res.status = STATUS_NO_FRAME;
        end else begin
          ring_push(g);
          pf_used[g]  = 1'b1;
          pf_ref[g]   = 1'b1;
          pf_dirty[g] = it.write_access;
          pf_kind[g]  = it.backing_kind;
          pf_block[g] = it.backing_block;
          res.granted_frame = g[FRAME_BITS-1:0];
        end
      end
      CMD_ACCESS: begin
        if (it.frame != 0 && pf_used[it.frame]) begin
          pf_ref[it.frame] = 1'b1;
          if (it.write_access) pf_dirty[it.frame] = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (it.frame != 0 && pf_used[it.frame]) begin
          pf_used[it.frame]  = 1'b0;
          pf_ref[it.frame]   = 1'b0;
          pf_dirty[it.frame] = 1'b0;
          ring_drop(int'(it.frame));
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on result %0d: %s got 0x%0h want 0x%0h", n_results, what, got, want);
    errors++;
  endtask

  // scoreboard: check results, track config, predict each accepted transaction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        pf_used[i]  = (i == 0);
        pf_ref[i]   = (i == 0);
        pf_dirty[i] = 1'b0;
        pf_kind[i]  = 1'b0;
        pf_block[i] = '0;
        ring[i]     = 0;
      end
      ring_head   = 0;
      ring_count  = 0;
      pred_frames = FRAMES_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          flag_mismatch("result with no transaction pending",
                        32'(out_data.granted_frame), 32'd0);
        end else begin
          want = outcome_q.pop_front();
          if (out_data.status !== want.status)
            flag_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.granted_frame !== want.granted_frame)
            flag_mismatch("granted_frame", 32'(out_data.granted_frame),
                          32'(want.granted_frame));
          if (out_data.victim_valid !== want.victim_valid)
            flag_mismatch("victim_valid", 32'(out_data.victim_valid),
                          32'(want.victim_valid));
          if (out_data.victim_writeback !== want.victim_writeback)
            flag_mismatch("victim_writeback", 32'(out_data.victim_writeback),
                          32'(want.victim_writeback));
          if (out_data.victim_kind !== want.victim_kind)
            flag_mismatch("victim_kind", 32'(out_data.victim_kind),
                          32'(want.victim_kind));
          if (out_data.victim_block !== want.victim_block)
            flag_mismatch("victim_block", 32'(out_data.victim_block),
                          32'(want.victim_block));
          if (want.victim_valid) n_evictions++;
        end
        n_results++;
      end
      if (cfg_we) begin
        pred_frames = cfg_wdata;
        n_cfg++;
      end
      if (in_valid && !in_stall) begin
        want = frame_outcome(in_data);
        outcome_q = {outcome_q, (fixed_valid ? fixed_want : want)};
        n_items++;
      end
    end
  end

  // result side: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLDOFF_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("clock_page_frame_allocator regression: fail");
    $finish;
  end

  task automatic send_item(in_item_t it, logic fixed, out_item_t want);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_data     <= it;
    fixed_valid <= fixed;
    fixed_want  <= want;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // hold the input quiet until every result is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    // let the scoreboard queue the transaction accepted at this edge
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_frames(logic [CNT_BITS-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    active_span = (value < FRAMES_MIN) ? 2 :
                  (value > FRAMES_RESET) ? NUM_FRAMES : int'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_item_t it;
    int r;
    send_idle = 35;
    recv_idle = 88;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].do_cfg) write_frames(DIRECTED[i].cfg_val);
      send_item(DIRECTED[i].item, DIRECTED[i].fixed, DIRECTED[i].want);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 4) begin
        send_idle = 35;
        recv_idle = 88;
      end else if (seg < 8) begin
        send_idle = 88;
        recv_idle = 35;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_frames(SEG_FRAMES[seg]);
      if (seg == 1 || seg == 9) hold_seq <= hold_seq + 1;
      for (int k = 0; k < SEG_ITEMS; k++) begin
        r = $urandom_range(99);
        it.cmd = (r < 45) ? CMD_ALLOC : (r < 75) ? CMD_ACCESS :
                 (r < 95) ? CMD_RELEASE : CMD_UNKNOWN;
        // mostly frames in the managed range, sometimes anywhere
        if ($urandom_range(99) < 85)
          it.frame = FRAME_BITS'($urandom_range(active_span - 1, 1));
        else it.frame = FRAME_BITS'($urandom_range(NUM_FRAMES - 1));
        it.write_access  = 1'($urandom_range(1));
        it.backing_kind  = 1'($urandom_range(1));
        it.backing_block = BLOCK_BITS'($urandom_range(16'hFFFF));
        send_item(it, 1'b0, NO_RESULT);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("ran %0d transactions through %0d frame-count writes, extremes included;",
             n_items, n_cfg);
    $display("checked %0d results, %0d of them second-chance evictions", n_results,
             n_evictions);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("clock_page_frame_allocator regression: pass");
    end else begin
      $display("clock_page_frame_allocator regression: fail");
    end
    $finish;
  end

endmodule
